// ===== rtl/swizzled_texel_byte_address_unit_defines.svh =====
// Assertion macros for the swizzled texel byte address unit.
// Both macros expect clk_i and rst_ni to be visible where they are used.
`ifndef SWIZZLED_TEXEL_BYTE_ADDRESS_UNIT_DEFINES_SVH
`define SWIZZLED_TEXEL_BYTE_ADDRESS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWZ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/swz_pkg.sv =====
// Shared constants, register and format codes, and stage types for the
// swizzled texel byte address unit. No dependencies.
`timescale 1ns / 1ps

package swz_pkg;

  localparam int unsigned MEMORY_BLOCKS = 16384;
  localparam int unsigned BLK_W         = $clog2(MEMORY_BLOCKS);
  localparam int unsigned ADDR_W        = 22;
  localparam int unsigned SUM_W         = 19;
  localparam int unsigned PAGE_W        = 13;
  localparam int unsigned PROD_W        = 12;
  localparam int unsigned BLOCK_SHIFT   = 8;   // 256 bytes per block
  localparam int unsigned PAGE_SHIFT    = 5;   // 32 blocks per page

  // APB register map, 64-bit registers at 8-byte spacing.
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_FORMS_VALID    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH16_XOR    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH32_XOR    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK32_BASES  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COLUMN32_BASES = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK16_BASES  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK16S_BASES = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_COLUMN16_BASES = 3'd7;

  // Storage format codes.
  localparam logic [5:0] PSM_C32  = 6'd0;
  localparam logic [5:0] PSM_C24  = 6'd1;
  localparam logic [5:0] PSM_C16  = 6'd2;
  localparam logic [5:0] PSM_C16S = 6'd10;
  localparam logic [5:0] PSM_Z32  = 6'd48;
  localparam logic [5:0] PSM_Z24  = 6'd49;
  localparam logic [5:0] PSM_Z16  = 6'd50;
  localparam logic [5:0] PSM_Z16S = 6'd58;

  typedef struct packed {
    logic        forms_valid;
    logic [13:0] depth16_block_xor;
    logic [4:0]  depth32_block_xor;
    logic [24:0] block32_bases;
    logic [35:0] column32_bases;
    logic [24:0] block16_bases;
    logic [24:0] block16s_bases;
    logic [48:0] column16_bases;
  } cfg_t;

  // First stage result: page row product and the XOR forms.
  typedef struct packed {
    logic              ok;
    logic [13:0]       base_block;
    logic [PROD_W-1:0] row_prod;
    logic [4:0]        page_col;
    logic [4:0]        inpage;
    logic [13:0]       block_xor;
    logic [7:0]        unit_bytes;
  } s1_t;

  // Second stage result: wrapped block number and offset in the block.
  typedef struct packed {
    logic             ok;
    logic [BLK_W-1:0] blk;
    logic [7:0]       unit_bytes;
  } s2_t;

endpackage

// ===== rtl/swz_cfg_regs.sv =====
// APB-style register file holding the swizzle forms and depth constants.
// Depends on swz_pkg.
`timescale 1ns / 1ps

module swz_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swz_pkg::PADDR_W-1:0] paddr,
  input  logic [swz_pkg::PDATA_W-1:0] pwdata,
  output logic [swz_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output swz_pkg::cfg_t               cfg_o
);

  swz_pkg::cfg_t                   cfg_q, cfg_d;
  logic [swz_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                            wr_en;

  assign reg_idx = paddr[swz_pkg::PADDR_W-1:3];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        swz_pkg::REG_FORMS_VALID:    cfg_d.forms_valid       = pwdata[0];
        swz_pkg::REG_DEPTH16_XOR:    cfg_d.depth16_block_xor = pwdata[13:0];
        swz_pkg::REG_DEPTH32_XOR:    cfg_d.depth32_block_xor = pwdata[4:0];
        swz_pkg::REG_BLOCK32_BASES:  cfg_d.block32_bases     = pwdata[24:0];
        swz_pkg::REG_COLUMN32_BASES: cfg_d.column32_bases    = pwdata[35:0];
        swz_pkg::REG_BLOCK16_BASES:  cfg_d.block16_bases     = pwdata[24:0];
        swz_pkg::REG_BLOCK16S_BASES: cfg_d.block16s_bases    = pwdata[24:0];
        swz_pkg::REG_COLUMN16_BASES: cfg_d.column16_bases    = pwdata[48:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      swz_pkg::REG_FORMS_VALID:    prdata = 64'(cfg_q.forms_valid);
      swz_pkg::REG_DEPTH16_XOR:    prdata = 64'(cfg_q.depth16_block_xor);
      swz_pkg::REG_DEPTH32_XOR:    prdata = 64'(cfg_q.depth32_block_xor);
      swz_pkg::REG_BLOCK32_BASES:  prdata = 64'(cfg_q.block32_bases);
      swz_pkg::REG_COLUMN32_BASES: prdata = 64'(cfg_q.column32_bases);
      swz_pkg::REG_BLOCK16_BASES:  prdata = 64'(cfg_q.block16_bases);
      swz_pkg::REG_BLOCK16S_BASES: prdata = 64'(cfg_q.block16s_bases);
      swz_pkg::REG_COLUMN16_BASES: prdata = 64'(cfg_q.column16_bases);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/swz_front.sv =====
// Format decode, page row product and the three XOR forms (first stage).
// Depends on swz_pkg.
`timescale 1ns / 1ps

module swz_front (
  input  logic [5:0]    pixel_format_i,
  input  logic [13:0]   base_block_i,
  input  logic [5:0]    buffer_width_i,
  input  logic [10:0]   texel_u_i,
  input  logic [10:0]   texel_v_i,
  input  swz_pkg::cfg_t cfg_i,
  output swz_pkg::s1_t  s1_o
);

  function automatic logic [4:0] xor_form5(input logic [24:0] bases, input logic [4:0] key);
    logic [4:0] acc;
    acc = '0;
    for (int i = 0; i < 5; i++) begin
      if (key[i]) acc ^= bases[i*5 +: 5];
    end
    return acc;
  endfunction

  function automatic logic [5:0] xor_form6(input logic [35:0] bases, input logic [5:0] key);
    logic [5:0] acc;
    acc = '0;
    for (int i = 0; i < 6; i++) begin
      if (key[i]) acc ^= bases[i*6 +: 6];
    end
    return acc;
  endfunction

  function automatic logic [6:0] xor_form7(input logic [48:0] bases, input logic [6:0] key);
    logic [6:0] acc;
    acc = '0;
    for (int i = 0; i < 7; i++) begin
      if (key[i]) acc ^= bases[i*7 +: 7];
    end
    return acc;
  endfunction

  logic       fam32, fam16, strided, depth;
  logic [5:0] page_row;
  logic [4:0] inpage32, inpage16;
  logic [5:0] unit32;
  logic [6:0] unit16;

  always_comb begin
    fam32   = 1'b0;
    fam16   = 1'b0;
    strided = 1'b0;
    unique case (pixel_format_i) inside
      swz_pkg::PSM_C32, swz_pkg::PSM_C24, swz_pkg::PSM_Z32, swz_pkg::PSM_Z24: fam32 = 1'b1;
      swz_pkg::PSM_C16, swz_pkg::PSM_Z16: fam16 = 1'b1;
      swz_pkg::PSM_C16S, swz_pkg::PSM_Z16S: begin
        fam16   = 1'b1;
        strided = 1'b1;
      end
      default: ;
    endcase
  end

  // Depth formats all sit in the upper half of the code space.
  assign depth = pixel_format_i[5];

  // 32-bit pages are 32 texels tall, 16-bit pages 64.
  assign page_row = fam32 ? texel_v_i[10:5] : {1'b0, texel_v_i[10:6]};

  assign inpage32 = xor_form5(cfg_i.block32_bases, {texel_v_i[4:3], texel_u_i[5:3]});
  assign inpage16 = xor_form5(strided ? cfg_i.block16s_bases : cfg_i.block16_bases,
                              {texel_v_i[5:3], texel_u_i[5:4]});
  assign unit32   = xor_form6(cfg_i.column32_bases, {texel_v_i[2:0], texel_u_i[2:0]});
  assign unit16   = xor_form7(cfg_i.column16_bases, {texel_v_i[2:0], texel_u_i[3:0]});

  always_comb begin
    s1_o.ok         = cfg_i.forms_valid && (fam32 || fam16);
    s1_o.base_block = base_block_i;
    s1_o.row_prod   = page_row * buffer_width_i;
    s1_o.page_col   = texel_u_i[10:6];
    if (fam32) begin
      s1_o.inpage     = inpage32;
      s1_o.block_xor  = depth ? 14'(cfg_i.depth32_block_xor) : '0;
      s1_o.unit_bytes = {unit32, 2'b00};
    end else begin
      s1_o.inpage     = inpage16;
      s1_o.block_xor  = depth ? cfg_i.depth16_block_xor : '0;
      s1_o.unit_bytes = {1'b0, unit16} << 1;
    end
  end

endmodule

// ===== rtl/swz_block.sv =====
// Absolute block number: page offset, base add, depth XOR and wrap to the
// memory's block count (second stage). Depends on swz_pkg.
`timescale 1ns / 1ps

module swz_block (
  input  swz_pkg::s1_t s1_i,
  output swz_pkg::s2_t s2_o
);

  logic [swz_pkg::PAGE_W-1:0] page;
  logic [swz_pkg::SUM_W-1:0]  sum;
  logic [swz_pkg::SUM_W-1:0]  mixed;

  assign page  = swz_pkg::PAGE_W'(s1_i.row_prod) + swz_pkg::PAGE_W'(s1_i.page_col);
  assign sum   = swz_pkg::SUM_W'(s1_i.base_block)
               + (swz_pkg::SUM_W'(page) << swz_pkg::PAGE_SHIFT)
               + swz_pkg::SUM_W'(s1_i.inpage);
  assign mixed = sum ^ swz_pkg::SUM_W'(s1_i.block_xor);

  // The block count is a power of two, so the wrap keeps the low bits.
  always_comb begin
    s2_o.ok         = s1_i.ok;
    s2_o.blk        = mixed[swz_pkg::BLK_W-1:0];
    s2_o.unit_bytes = s1_i.unit_bytes;
  end

endmodule

// ===== rtl/swizzled_texel_byte_address_unit.sv =====
// Top level of the swizzled texel byte address unit: three-stage pipeline
// over swz_front and swz_block, register file swz_cfg_regs; uses swz_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   input   | in        | in_valid_i, in_ready_o | pixel_format, base_block, buffer_width,
//           |           |                        | texel_u, texel_v
//   output  | out       | out_valid_o, out_ready_i | address_ok, byte_address
//   config  | in        | APB psel/penable/pready  | paddr, pwdata, prdata
//
// A texel beat is captured into the first stage when it is accepted, then passes
// through the second stage into the output register, from which it can leave;
// one beat is taken every cycle when the output is drained.
// The depth is set by the decode and multiply stage, the block add stage and
// the final address assembly stage.
// Reset clears the stage valid bits and the configuration registers; no clearing pass is needed.
// A stall on the output holds every full stage that has no empty stage after it; an empty stage still fills.
`timescale 1ns / 1ps

`include "swizzled_texel_byte_address_unit_defines.svh"

module swizzled_texel_byte_address_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swz_pkg::PADDR_W-1:0] paddr,
  input  logic [swz_pkg::PDATA_W-1:0] pwdata,
  output logic [swz_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [5:0]                  pixel_format_i,
  input  logic [13:0]                 base_block_i,
  input  logic [5:0]                  buffer_width_i,
  input  logic [10:0]                 texel_u_i,
  input  logic [10:0]                 texel_v_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        address_ok_o,
  output logic [21:0]                 byte_address_o
);

  swz_pkg::cfg_t cfg;
  swz_pkg::s1_t  s1_d, s1_q;
  swz_pkg::s2_t  s2_d, s2_q;

  logic        v1_q, v2_q, vo_q;
  logic        en1, en2, en3;
  logic        ok_q;
  logic [21:0] addr_d, addr_q;

  swz_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swz_front u_front (
    .pixel_format_i (pixel_format_i),
    .base_block_i   (base_block_i),
    .buffer_width_i (buffer_width_i),
    .texel_u_i      (texel_u_i),
    .texel_v_i      (texel_v_i),
    .cfg_i          (cfg),
    .s1_o           (s1_d)
  );

  swz_block u_block (
    .s1_i (s1_q),
    .s2_o (s2_d)
  );

  // A stage may load when it is empty or when its contents move on.
  assign en3        = !vo_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // Refused beats carry a zero address.
  assign addr_d = s2_q.ok
                ? ((swz_pkg::ADDR_W'(s2_q.blk) << swz_pkg::BLOCK_SHIFT)
                   + swz_pkg::ADDR_W'(s2_q.unit_bytes))
                : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) vo_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) s1_q <= s1_d;
    if (en2 && v1_q) s2_q <= s2_d;
    if (en3 && v2_q) begin
      ok_q   <= s2_q.ok;
      addr_q <= addr_d;
    end
  end

  assign out_valid_o    = vo_q;
  assign address_ok_o   = ok_q;
  assign byte_address_o = addr_q;

  `SWZ_ASSERT_NEXT(a_accept_fills, in_valid_i && in_ready_o, v1_q, "accepted beat lost at stage one")
  `SWZ_ASSERT_NOW(a_full_blocks, vo_q && !out_ready_i && v1_q && v2_q, !in_ready_o, "input taken into a full pipeline")
  `SWZ_ASSERT_NEXT(a_stage2_holds, v2_q && !en3, v2_q && $stable(s2_q), "stalled stage two changed")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for swizzled_texel_byte_address_unit: a predictor works out each
// texel's byte address as it is accepted and the monitor compares results in order.
// Depends on swz_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [5:0]  PSM_UNKNOWN_TOP  = 6'd63;
  localparam logic [5:0]  PSM_UNKNOWN_NEAR = 6'd51;

  typedef struct packed {
    logic [5:0]  pixel_format;
    logic [13:0] base_block;
    logic [5:0]  buffer_width;
    logic [10:0] texel_u;
    logic [10:0] texel_v;
  } texel_req_t;

  typedef struct packed {
    logic        address_ok;
    logic [21:0] byte_address;
  } texel_address_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [swz_pkg::PADDR_W-1:0]  paddr = '0;
  logic [swz_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [swz_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [5:0]                   pixel_format_i = '0;
  logic [13:0]                  base_block_i = '0;
  logic [5:0]                   buffer_width_i = '0;
  logic [10:0]                  texel_u_i = '0;
  logic [10:0]                  texel_v_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic                         address_ok_o;
  logic [21:0]                  byte_address_o;

  swizzled_texel_byte_address_unit dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .pixel_format_i, .base_block_i, .buffer_width_i,
    .texel_u_i, .texel_v_i, .out_valid_o, .out_ready_i, .address_ok_o, .byte_address_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  swz_pkg::cfg_t  setup = '0;
  texel_req_t     texel_queue[$];
  texel_address_t expected_addresses[$];
  texel_req_t     offered_texel;
  texel_address_t wanted;
  int unsigned    mismatches = 0;
  int unsigned    send_gap = 0;
  int unsigned    stall_left = 0;
  int unsigned    hold_token = 0;
  int unsigned    seen_hold = 0;
  bit             idle_on = 1'b1;

  task automatic log_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // XOR of the basis words selected by the set bits of key.
  function automatic int unsigned xor_fold(logic [63:0] bases, int unsigned wbits,
                                           int unsigned nbits, int unsigned key);
    int unsigned acc;
    logic [63:0] word_mask;
    acc = 0;
    word_mask = (64'd1 << wbits) - 64'd1;
    for (int unsigned i = 0; i < nbits; i++) begin
      if (((key >> i) & 1) != 0) acc = acc ^ 32'((bases >> (i * wbits)) & word_mask);
    end
    return acc;
  endfunction

  function automatic texel_address_t predict_address(swz_pkg::cfg_t c, texel_req_t t);
    texel_address_t r;
    logic is32, is16, depth, strided;
    int unsigned u, v, tbp, tbw, page, inpage, blk, unit, addr, zx, key;
    r = '0;
    u = 32'(t.texel_u);
    v = 32'(t.texel_v);
    tbp = 32'(t.base_block);
    tbw = 32'(t.buffer_width);
    is32 = (t.pixel_format == swz_pkg::PSM_C32) || (t.pixel_format == swz_pkg::PSM_C24) ||
           (t.pixel_format == swz_pkg::PSM_Z32) || (t.pixel_format == swz_pkg::PSM_Z24);
    is16 = (t.pixel_format == swz_pkg::PSM_C16) || (t.pixel_format == swz_pkg::PSM_C16S) ||
           (t.pixel_format == swz_pkg::PSM_Z16) || (t.pixel_format == swz_pkg::PSM_Z16S);
    depth = (t.pixel_format == swz_pkg::PSM_Z32) || (t.pixel_format == swz_pkg::PSM_Z24) ||
            (t.pixel_format == swz_pkg::PSM_Z16) || (t.pixel_format == swz_pkg::PSM_Z16S);
    strided = (t.pixel_format == swz_pkg::PSM_C16S) || (t.pixel_format == swz_pkg::PSM_Z16S);
    if (!c.forms_valid || !(is32 || is16)) return r;
    if (is32) begin
      zx = depth ? 32'(c.depth32_block_xor) : 0;
      page = (v >> 5) * tbw + (u >> 6);
      key = ((u >> 3) & 7) | (((v >> 3) & 3) << 3);
      inpage = xor_fold(64'(c.block32_bases), 5, 5, key);
      blk = ((tbp + page * 32 + inpage) ^ zx) % swz_pkg::MEMORY_BLOCKS;
      unit = xor_fold(64'(c.column32_bases), 6, 6, (u & 7) | ((v & 7) << 3));
      addr = blk * 256 + unit * 4;
    end else begin
      zx = depth ? 32'(c.depth16_block_xor) : 0;
      page = (v >> 6) * tbw + (u >> 6);
      key = ((u >> 4) & 3) | (((v >> 3) & 7) << 2);
      inpage = xor_fold(strided ? 64'(c.block16s_bases) : 64'(c.block16_bases), 5, 5, key);
      blk = ((tbp + page * 32 + inpage) ^ zx) % swz_pkg::MEMORY_BLOCKS;
      unit = xor_fold(64'(c.column16_bases), 7, 7, (u & 15) | ((v & 7) << 4));
      addr = blk * 256 + unit * 2;
    end
    r.address_ok = 1'b1;
    r.byte_address = addr[21:0];
    return r;
  endfunction

  function automatic swz_pkg::cfg_t update_setup(swz_pkg::cfg_t c, logic [2:0] idx,
                                                 logic [63:0] value);
    case (idx)
      swz_pkg::REG_FORMS_VALID:    c.forms_valid = value[0];
      swz_pkg::REG_DEPTH16_XOR:    c.depth16_block_xor = value[13:0];
      swz_pkg::REG_DEPTH32_XOR:    c.depth32_block_xor = value[4:0];
      swz_pkg::REG_BLOCK32_BASES:  c.block32_bases = value[24:0];
      swz_pkg::REG_COLUMN32_BASES: c.column32_bases = value[35:0];
      swz_pkg::REG_BLOCK16_BASES:  c.block16_bases = value[24:0];
      swz_pkg::REG_BLOCK16S_BASES: c.block16s_bases = value[24:0];
      default:                     c.column16_bases = value[48:0];
    endcase
    return c;
  endfunction

  function automatic logic [63:0] setting_of(swz_pkg::cfg_t c, logic [2:0] idx);
    logic [63:0] v;
    v = '0;
    case (idx)
      swz_pkg::REG_FORMS_VALID:    v = 64'(c.forms_valid);
      swz_pkg::REG_DEPTH16_XOR:    v = 64'(c.depth16_block_xor);
      swz_pkg::REG_DEPTH32_XOR:    v = 64'(c.depth32_block_xor);
      swz_pkg::REG_BLOCK32_BASES:  v = 64'(c.block32_bases);
      swz_pkg::REG_COLUMN32_BASES: v = 64'(c.column32_bases);
      swz_pkg::REG_BLOCK16_BASES:  v = 64'(c.block16_bases);
      swz_pkg::REG_BLOCK16S_BASES: v = 64'(c.block16s_bases);
      default:                     v = 64'(c.column16_bases);
    endcase
    return v;
  endfunction

  function automatic logic [5:0] known_format(int unsigned k);
    case (k)
      0:       return swz_pkg::PSM_C32;
      1:       return swz_pkg::PSM_C24;
      2:       return swz_pkg::PSM_Z32;
      3:       return swz_pkg::PSM_Z24;
      4:       return swz_pkg::PSM_C16;
      5:       return swz_pkg::PSM_C16S;
      6:       return swz_pkg::PSM_Z16;
      default: return swz_pkg::PSM_Z16S;
    endcase
  endfunction

  function automatic texel_req_t make_texel(logic [5:0] fmt, logic [13:0] base,
                                            logic [5:0] width, logic [10:0] u, logic [10:0] v);
    texel_req_t t;
    t.pixel_format = fmt;
    t.base_block = base;
    t.buffer_width = width;
    t.texel_u = u;
    t.texel_v = v;
    return t;
  endfunction

  // Mostly served formats with random content; the rest are arbitrary codes.
  function automatic texel_req_t random_texel();
    logic [5:0] fmt;
    if ($urandom_range(0, 99) < 85) fmt = known_format($urandom_range(0, 7));
    else fmt = 6'($urandom);
    return make_texel(fmt, 14'($urandom), 6'($urandom), 11'($urandom), 11'($urandom));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender: a beat leaves the queue only once the previous one has been taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_addresses.push_back(predict_address(setup, offered_texel));
        send_gap = pick_gap();
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (texel_queue.size() != 0) begin
          offered_texel = texel_queue.pop_front();
          pixel_format_i <= offered_texel.pixel_format;
          base_block_i <= offered_texel.base_block;
          buffer_width_i <= offered_texel.buffer_width;
          texel_u_i <= offered_texel.texel_u;
          texel_v_i <= offered_texel.texel_v;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and decides when to stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      seen_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_addresses.size() == 0) begin
          log_error($sformatf("unexpected result: ok=%0b address=%h",
                              address_ok_o, byte_address_o));
        end else begin
          wanted = expected_addresses.pop_front();
          if (address_ok_o !== wanted.address_ok || byte_address_o !== wanted.byte_address)
            log_error($sformatf("result mismatch: ok=%0b address=%h, expected ok=%0b address=%h",
                                address_ok_o, byte_address_o,
                                wanted.address_ok, wanted.byte_address));
        end
      end
      if (hold_token != seen_hold) begin
        seen_hold = hold_token;
        stall_left = LONG_HOLD;
      end else if (out_valid_o && out_ready_i) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic apb_transfer(input logic is_write, input logic [2:0] idx,
                              input logic [63:0] wdata, output logic [63:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {idx, 3'b000};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_register(input logic [2:0] idx, input logic [63:0] value);
    logic [63:0] readback;
    apb_transfer(1'b1, idx, value, readback);
    setup = update_setup(setup, idx, value);
    apb_transfer(1'b0, idx, '0, readback);
    if ((readback & setting_of('1, idx)) !== setting_of(setup, idx))
      log_error($sformatf("register %0d reads %h, expected %h",
                          idx, readback, setting_of(setup, idx)));
  endtask

  task automatic program_setup(input logic forms_on, input bit randomise,
                               input logic [63:0] fill);
    set_register(swz_pkg::REG_FORMS_VALID, 64'(forms_on));
    set_register(swz_pkg::REG_DEPTH16_XOR, randomise ? {$urandom, $urandom} : fill);
    set_register(swz_pkg::REG_DEPTH32_XOR, randomise ? {$urandom, $urandom} : fill);
    set_register(swz_pkg::REG_BLOCK32_BASES, randomise ? {$urandom, $urandom} : fill);
    set_register(swz_pkg::REG_COLUMN32_BASES, randomise ? {$urandom, $urandom} : fill);
    set_register(swz_pkg::REG_BLOCK16_BASES, randomise ? {$urandom, $urandom} : fill);
    set_register(swz_pkg::REG_BLOCK16S_BASES, randomise ? {$urandom, $urandom} : fill);
    set_register(swz_pkg::REG_COLUMN16_BASES, randomise ? {$urandom, $urandom} : fill);
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) texel_queue.push_back(random_texel());
  endtask

  // Returns once every queued beat has gone through and the pipeline has emptied.
  // The check runs on the falling edge, after the sender's updates have settled.
  task automatic settle_pipeline();
    while (texel_queue.size() != 0 || in_valid_i || expected_addresses.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers still at reset, so every address is refused.
    queue_random(12);
    settle_pipeline();

    // Directed pass with every register at its top value.
    program_setup(1'b1, 1'b0, '1);
    for (int k = 0; k < 8; k++) begin
      texel_queue.push_back(make_texel(known_format(k), '1, '1, '1, '1));
      texel_queue.push_back(make_texel(known_format(k), '0, '0, '0, '0));
    end
    texel_queue.push_back(make_texel(swz_pkg::PSM_C32, 14'($urandom), '0,
                                     11'($urandom), 11'($urandom)));
    texel_queue.push_back(make_texel(swz_pkg::PSM_Z16S, 14'($urandom), '0,
                                     11'($urandom), 11'($urandom)));
    texel_queue.push_back(make_texel(PSM_UNKNOWN_TOP, '1, '1, '1, '1));
    texel_queue.push_back(make_texel(PSM_UNKNOWN_NEAR, 14'($urandom), 6'($urandom),
                                     11'($urandom), 11'($urandom)));
    queue_random(2);
    settle_pipeline();

    for (int p = 0; p < 7; p++) begin
      if (p == 1) program_setup(1'b1, 1'b0, '0);
      else program_setup(p != 3, 1'b1, '0);
      idle_on = (p % 2 == 0);
      queue_random(110);
      // Hold the result side off while the sender keeps offering beats.
      if (p == 2) hold_token++;
      settle_pipeline();
    end

    if (mismatches == 0 && expected_addresses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/swz_pkg.sv
rtl/swz_cfg_regs.sv
rtl/swz_front.sv
rtl/swz_block.sv
rtl/swizzled_texel_byte_address_unit.sv
tb/tb_top.sv
